>>> rtl/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg: shared types for the LIFO stack with replace
// Operation and status codes, the item payload structs and the control
// bundle that the top level hands to every stack cell.
// ----------------------------------------------------------------------------
package lsr_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;
  localparam int OCC_W         = 5;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_CHANGE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOMATCH  = 2'd3
  } status_t;

  typedef struct packed {
    action_t action;
    word_t   value;
    word_t   match_value;
  } req_t;

  typedef struct packed {
    status_t          status;
    word_t            read_value;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  // Per-cycle command shared by all cells of the chain
  typedef struct packed {
    logic push_en;
    logic pop_en;
    logic chg_en;
  } lsr_ctrl_t;

endpackage

>>> rtl/lsr_cell.sv
// ----------------------------------------------------------------------------
// lsr_cell: one word of the stack chain
// Holds one entry, shifts with its neighbors on push and pop, and compares
// against the match value so the chain can pick the topmost hit on change.
// ----------------------------------------------------------------------------
module lsr_cell (
  input  logic              clk,
  input  lsr_pkg::lsr_ctrl_t ctrl,
  input  lsr_pkg::word_t    above_data,
  input  lsr_pkg::word_t    below_data,
  input  lsr_pkg::word_t    value,
  input  lsr_pkg::word_t    match_value,
  input  logic              occupied,
  input  logic              hit_in,
  output lsr_pkg::word_t    data,
  output logic              hit_out
);

  logic hit;

  // Compare the held entry; pass any hit above or here down the chain
  assign hit     = occupied && (data == match_value);
  assign hit_out = hit_in || hit;

  // Shift down on push, up on pop, overwrite the topmost hit on change
  always_ff @(posedge clk) begin
    if (ctrl.push_en) begin
      data <= above_data;
    end else if (ctrl.pop_en) begin
      data <= below_data;
    end else if (ctrl.chg_en && hit && !hit_in) begin
      data <= value;
    end
  end

endmodule

>>> rtl/lifo_stack_with_replace.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_replace: bounded LIFO stack of signed words with replace
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle for every operation; each cell shifts or
// compares its own entry in the same cycle, and the result register frees
// itself whenever the consumer takes the result.
// Reset: rst clears the entry count and the result valid; entries are not
// cleared and are only read once pushed.
// ----------------------------------------------------------------------------
module lifo_stack_with_replace #(
  parameter int DEPTH = lsr_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lsr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lsr_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic [CNT_W+lsr_pkg::OCC_W-1:0] occ_wide;
  logic                       accept;
  logic                       full;
  logic                       empty;
  lsr_pkg::lsr_ctrl_t         ctrl;
  lsr_pkg::word_t             cell_data [DEPTH];
  logic [DEPTH:0]             hit_chain;
  lsr_pkg::rsp_t              rsp_next;

  // Handshake: take an item whenever the result register is free or draining
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  // Decode the command for the chain
  always_comb begin
    ctrl.push_en = accept && (req.action == lsr_pkg::ACT_PUSH) && !full;
    ctrl.pop_en  = accept && (req.action == lsr_pkg::ACT_POP) && !empty;
    ctrl.chg_en  = accept && (req.action == lsr_pkg::ACT_CHANGE);
  end

  // Build the chain: cell 0 is the top of the stack
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lsr_pkg::word_t above_data;
    lsr_pkg::word_t below_data;
    logic           occupied;

    if (i == 0) begin : g_top
      assign above_data = req.value;
    end else begin : g_mid_above
      assign above_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign below_data = cell_data[i];
    end else begin : g_mid_below
      assign below_data = cell_data[i+1];
    end

    assign occupied = (count > CNT_W'(i));

    lsr_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .above_data  (above_data),
      .below_data  (below_data),
      .value       (req.value),
      .match_value (req.match_value),
      .occupied    (occupied),
      .hit_in      (hit_chain[i]),
      .data        (cell_data[i]),
      .hit_out     (hit_chain[i+1])
    );
  end

  // Advance the entry count
  always_comb begin
    count_next = count;
    if (ctrl.push_en) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pop_en) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign occ_wide = (CNT_W + lsr_pkg::OCC_W)'(count_next);

  // Form the result for the accepted item
  always_comb begin
    rsp_next.status     = lsr_pkg::ST_OK;
    rsp_next.read_value = '0;
    rsp_next.occupancy  = occ_wide[lsr_pkg::OCC_W-1:0];
    case (req.action)
      lsr_pkg::ACT_PUSH: begin
        if (full) begin
          rsp_next.status = lsr_pkg::ST_OVERFLOW;
        end
      end
      lsr_pkg::ACT_POP, lsr_pkg::ACT_PEEK: begin
        if (empty) begin
          rsp_next.status = lsr_pkg::ST_EMPTY;
        end else begin
          rsp_next.read_value = cell_data[0];
        end
      end
      lsr_pkg::ACT_CHANGE: begin
        if (!hit_chain[DEPTH]) begin
          rsp_next.status = lsr_pkg::ST_NOMATCH;
        end
      end
      default: begin
        rsp_next.status = lsr_pkg::ST_OK;
      end
    endcase
  end

  // Hold count and the result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> rtl/lsr_checker.sv
// ----------------------------------------------------------------------------
// lsr_checker: port-level checks for the LIFO stack with replace
// Watches the result channel and the status codes against occupancy.
// ----------------------------------------------------------------------------
module lsr_checker #(
  parameter int DEPTH = lsr_pkg::DEPTH_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input lsr_pkg::rsp_t rsp
);

  localparam logic [lsr_pkg::OCC_W-1:0] DEPTH_LO = lsr_pkg::OCC_W'(DEPTH);

  // A stalled result holds its value
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result dropped or changed while stalled");

  // Reset empties the result register
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Overflow only when the stack is full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == lsr_pkg::ST_OVERFLOW) |-> rsp.occupancy == DEPTH_LO)
    else $error("overflow reported with room left");

  // Empty status only when nothing is held
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == lsr_pkg::ST_EMPTY) |-> rsp.occupancy == '0)
    else $error("empty reported with entries held");

  // An item is taken only while the result register can accept it
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> !rsp_valid || rsp_ready)
    else $error("item taken while result stalled");

endmodule

bind lifo_stack_with_replace lsr_checker #(.DEPTH(DEPTH)) u_lsr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

>>> tb/sv/lifo_stack_with_replace_test.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_replace_test: self-checking bench for the LIFO stack
// Runs a directed table (empty stack, extreme words, deep and top change,
// overflow at full depth), then random operation mixes that fill and drain
// the stack under several sender and receiver idling patterns. Every result
// is compared field by field with the typed table row or a behavioral stack model.
// ----------------------------------------------------------------------------
module lifo_stack_with_replace_test;

  localparam int DEPTH       = lsr_pkg::DEPTH_DEFAULT;
  localparam int PHASE_ITEMS = 475;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  localparam lsr_pkg::word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam lsr_pkg::word_t WORD_MIN = 32'sh8000_0000;

  // Operation mixes for the random part
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    lsr_pkg::req_t cmd;
    logic [4:0]    reps;
    logic          typed;
    lsr_pkg::rsp_t want;
  } step_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  lsr_pkg::req_t req_bus = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  lsr_pkg::rsp_t rsp_bus;

  // Behavioral copy of the stack
  lsr_pkg::word_t stk_mem [DEPTH];
  int             stk_cnt = 0;

  lsr_pkg::rsp_t pending_rsp [$];
  step_t         dir_rows [$];
  int            err_count = 0;
  int            send_idle = 0;
  int            recv_idle = 0;
  lsr_pkg::rsp_t head_rsp;

  always #6 clk = ~clk;

  lifo_stack_with_replace #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_bus),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp_bus)
  );

  // Apply one operation to the model stack and return its result
  function automatic lsr_pkg::rsp_t stack_apply(lsr_pkg::req_t cmd);
    lsr_pkg::rsp_t r;
    int            i;
    r = '0;
    r.status = lsr_pkg::ST_OK;
    case (cmd.action)
      lsr_pkg::ACT_PUSH: begin
        if (stk_cnt >= DEPTH) begin
          r.status = lsr_pkg::ST_OVERFLOW;
        end else begin
          stk_mem[stk_cnt] = cmd.value;
          stk_cnt++;
        end
      end
      lsr_pkg::ACT_POP: begin
        if (stk_cnt == 0) begin
          r.status = lsr_pkg::ST_EMPTY;
        end else begin
          stk_cnt--;
          r.read_value = stk_mem[stk_cnt];
        end
      end
      lsr_pkg::ACT_PEEK: begin
        if (stk_cnt == 0) r.status = lsr_pkg::ST_EMPTY;
        else r.read_value = stk_mem[stk_cnt - 1];
      end
      default: begin
        r.status = lsr_pkg::ST_NOMATCH;
        for (i = stk_cnt - 1; i >= 0; i--) begin
          if (stk_mem[i] == cmd.match_value) begin
            stk_mem[i] = cmd.value;
            r.status = lsr_pkg::ST_OK;
            break;
          end
        end
      end
    endcase
    r.occupancy = lsr_pkg::OCC_W'(stk_cnt);
    return r;
  endfunction

  // Favor corner words and small repeats so change finds matches
  function automatic lsr_pkg::word_t pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return -1;
      4, 5, 6: return lsr_pkg::word_t'($urandom_range(0, 7));
      default: return lsr_pkg::word_t'($urandom);
    endcase
  endfunction

  // Draw the next random operation for the given mix
  function automatic lsr_pkg::req_t pick_request(int mix);
    lsr_pkg::req_t cmd;
    int            roll;
    int            push_pct;
    int            pop_pct;
    roll = $urandom_range(0, 99);
    push_pct = (mix == MIX_FILL) ? 55 : (mix == MIX_DRAIN) ? 15 : 30;
    pop_pct  = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 55 : 30;
    cmd.value = pick_word();
    cmd.match_value = lsr_pkg::word_t'($urandom);
    if (roll < push_pct) cmd.action = lsr_pkg::ACT_PUSH;
    else if (roll < push_pct + pop_pct) cmd.action = lsr_pkg::ACT_POP;
    else if (roll < push_pct + pop_pct + 10) cmd.action = lsr_pkg::ACT_PEEK;
    else cmd.action = lsr_pkg::ACT_CHANGE;
    // Aim most changes at a live entry
    if (cmd.action == lsr_pkg::ACT_CHANGE) begin
      if (stk_cnt > 0 && $urandom_range(0, 3) != 0)
        cmd.match_value = stk_mem[$urandom_range(0, stk_cnt - 1)];
      else
        cmd.match_value = pick_word();
    end
    return cmd;
  endfunction

  function automatic void add_row(lsr_pkg::action_t act, lsr_pkg::word_t val,
                                  lsr_pkg::word_t mval, int reps, bit typed,
                                  lsr_pkg::status_t st, lsr_pkg::word_t rd, int occ);
    step_t s;
    s.cmd.action = act;
    s.cmd.value = val;
    s.cmd.match_value = mval;
    s.reps = 5'(reps);
    s.typed = typed;
    s.want.status = st;
    s.want.read_value = rd;
    s.want.occupancy = lsr_pkg::OCC_W'(occ);
    dir_rows.push_back(s);
  endfunction

  function automatic void log_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Offer one item after a random gap, hold it until taken, then predict
  task automatic send_item(lsr_pkg::req_t cmd, bit typed, lsr_pkg::rsp_t want);
    lsr_pkg::rsp_t model_rsp;
    while ($urandom_range(0, 99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_bus <= cmd;
    do @(posedge clk); while (!req_ready);
    model_rsp = stack_apply(cmd);
    pending_rsp.push_back(typed ? want : model_rsp);
  endtask

  // Hold the sender off until every expected result has come back
  task automatic drain_results();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Stall the result side at random
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        log_error($sformatf("unexpected result: status %0d read_value %0d occupancy %0d",
                            rsp_bus.status, rsp_bus.read_value, rsp_bus.occupancy));
      end else begin
        head_rsp = pending_rsp.pop_front();
        if (rsp_bus.status !== head_rsp.status ||
            rsp_bus.read_value !== head_rsp.read_value ||
            rsp_bus.occupancy !== head_rsp.occupancy) begin
          log_error($sformatf({"mismatch: status exp %0d got %0d, read_value exp %0d ",
                               "got %0d, occupancy exp %0d got %0d"},
                              head_rsp.status, rsp_bus.status,
                              head_rsp.read_value, rsp_bus.read_value,
                              head_rsp.occupancy, rsp_bus.occupancy));
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int    n;
    int    k;
    int    phase;
    int    mix;
    int    mix_left;
    step_t s;

    // Empty stack, extreme words, deep then top change, fill to overflow
    add_row(lsr_pkg::ACT_POP,    '0,       '0,       1, 1, lsr_pkg::ST_EMPTY,   '0, 0);
    add_row(lsr_pkg::ACT_PEEK,   '0,       '0,       1, 1, lsr_pkg::ST_EMPTY,   '0, 0);
    add_row(lsr_pkg::ACT_CHANGE, 32'sd9,   '0,       1, 1, lsr_pkg::ST_NOMATCH, '0, 0);
    add_row(lsr_pkg::ACT_PUSH,   WORD_MAX, '0,       1, 1, lsr_pkg::ST_OK,      '0, 1);
    add_row(lsr_pkg::ACT_PUSH,   WORD_MIN, '0,       1, 1, lsr_pkg::ST_OK,      '0, 2);
    add_row(lsr_pkg::ACT_PEEK,   '0,       '0,       1, 1, lsr_pkg::ST_OK, WORD_MIN, 2);
    add_row(lsr_pkg::ACT_CHANGE, '0,       WORD_MAX, 1, 0, lsr_pkg::ST_OK,      '0, 0);
    add_row(lsr_pkg::ACT_PUSH,   WORD_MIN, WORD_MAX, 1, 0, lsr_pkg::ST_OK,      '0, 0);
    add_row(lsr_pkg::ACT_CHANGE, 32'sd5,   WORD_MIN, 1, 0, lsr_pkg::ST_OK,      '0, 0);
    add_row(lsr_pkg::ACT_POP,    -1,       -1,       1, 0, lsr_pkg::ST_OK,      '0, 0);
    add_row(lsr_pkg::ACT_CHANGE, -1,       32'sd77,  1, 0, lsr_pkg::ST_OK,      '0, 0);
    add_row(lsr_pkg::ACT_PUSH,   32'sh5555_5555, 32'shAAAA_AAAA, 14, 0,
            lsr_pkg::ST_OK, '0, 0);
    add_row(lsr_pkg::ACT_PUSH,   32'sh1234_5678, '0, 1, 1,
            lsr_pkg::ST_OVERFLOW, '0, DEPTH);
    add_row(lsr_pkg::ACT_POP,    '0, '0, 1, 1,
            lsr_pkg::ST_OK, 32'sh5555_5555, DEPTH - 1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (dir_rows[n]) begin
      s = dir_rows[n];
      for (k = 0; k < s.reps; k++) send_item(s.cmd, s.typed, s.want);
    end
    drain_results();

    // Random mixes: no idling, sender idle, receiver stall, both
    mix = MIX_EVEN;
    mix_left = 0;
    for (phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 1) ? 59 : (phase == 3) ? 32 : 0;
      recv_idle = (phase == 2) ? 59 : (phase == 3) ? 32 : 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (mix_left == 0) begin
          mix = $urandom_range(MIX_FILL, MIX_EVEN);
          mix_left = $urandom_range(20, 60);
        end
        mix_left--;
        send_item(pick_request(mix), 1'b0, '0);
      end
      drain_results();
    end

    // Let the last result register settle, then report
    recv_idle = 0;
    repeat (4) @(posedge clk);
    if (pending_rsp.size() != 0)
      log_error($sformatf("%0d results never arrived", pending_rsp.size()));
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
